>>> sv/assert_macros.svh
// Assertion macros used by the top level of the min/max tracker block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also checks across reset.
`define ASSERT_CLK_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/mmtn_pkg.sv
// Types, constants and codes of the min/max tracker normalizer.
package mmtn_pkg;

  localparam int TRACKERS  = 16;
  localparam int TRK_IDX_W = (TRACKERS > 1) ? $clog2(TRACKERS) : 1;

  localparam logic signed [31:0] EMPTY_MIN = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] EMPTY_MAX = 32'sh8000_0000;
  localparam logic signed [31:0] SAT_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN   = 32'sh8000_0000;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_NORM   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic REG_DELTA_FLOOR = 1'b0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         tracker_index;
    logic signed [31:0] sample_value;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] normalized_value;
    logic signed [31:0] current_min;
    logic signed [31:0] current_max;
  } result_t;

  // Work handed from the front to the back.
  typedef struct packed {
    logic               need_div;
    logic signed [31:0] pass_value;
    logic [32:0]        numer;
    logic [31:0]        divisor;
    logic signed [31:0] cur_min;
    logic signed [31:0] cur_max;
  } job_t;

endpackage

>>> sv/mmtn_front.sv
// Front end: tracker bank, min/max update and clear, divide setup.
module mmtn_front import mmtn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [30:0] delta_floor,
  input  logic        sample_valid,
  input  sample_t     sample,
  input  logic        q_full,
  output logic        push,
  output job_t        job
);

  logic signed [31:0] tracker_min [TRACKERS];
  logic signed [31:0] tracker_max [TRACKERS];

  logic [TRK_IDX_W-1:0] sel;
  logic                 idx_ok;
  logic signed [31:0]   lo, hi, x;
  logic signed [31:0]   min_next, max_next;
  logic [32:0]          span;
  logic                 span_pos;
  logic                 is_norm;

  assign push = sample_valid && !q_full;

  always_comb begin
    sel      = TRK_IDX_W'(sample.tracker_index);
    idx_ok   = 32'(sample.tracker_index) < TRACKERS;
    lo       = tracker_min[sel];
    hi       = tracker_max[sel];
    x        = sample.sample_value;
    min_next = lo;
    max_next = hi;
    case (sample.op)
      OP_UPDATE: begin
        if (x > hi) max_next = x;
        if (x < lo) min_next = x;
      end
      OP_CLEAR: begin
        min_next = EMPTY_MIN;
        max_next = EMPTY_MAX;
      end
      default: ;
    endcase

    span     = {hi[31], hi} - {lo[31], lo};
    span_pos = !span[32] && (span != '0);
    is_norm  = idx_ok && (sample.op == OP_NORM);

    job.need_div   = is_norm && span_pos;
    job.pass_value = (is_norm && !span_pos) ? x : '0;
    job.numer      = {x[31], x} - {lo[31], lo};
    // span is positive whenever the divisor is used, so 32 bits hold it
    job.divisor    = (span[31:0] < {1'b0, delta_floor}) ? {1'b0, delta_floor} : span[31:0];
    job.cur_min    = idx_ok ? min_next : '0;
    job.cur_max    = idx_ok ? max_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRACKERS; i++) begin
        tracker_min[i] <= EMPTY_MIN;
        tracker_max[i] <= EMPTY_MAX;
      end
    end else if (push && idx_ok) begin
      tracker_min[sel] <= min_next;
      tracker_max[sel] <= max_next;
    end
  end

endmodule

>>> sv/mmtn_queue.sv
// Short FIFO of jobs between the front and the back.
module mmtn_queue import mmtn_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  job_t  push_job,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output job_t  pop_job
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign pop_job = entries[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/mmtn_back.sv
// Back end: radix-2 divider, saturation and the output register.
module mmtn_back import mmtn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  job_t    job,
  output logic    pop,
  output logic    result_valid,
  output result_t result,
  input  logic    result_stall
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]           state;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          rem, dq, d;
  logic                 neg, sat;
  logic signed [31:0]   hold_min, hold_max;

  logic                 out_free;
  logic                 load;
  logic [32:0]          neg_numer;
  logic [31:0]          mag;
  logic [32:0]          trial, diff;
  logic                 ge;
  logic [31:0]          neg_dq;
  logic signed [31:0]   quot;

  assign out_free = !result_valid || !result_stall;
  assign pop      = (state == ST_IDLE) && q_valid && out_free;
  assign load     = (pop && !job.need_div) || ((state == ST_FIN) && out_free);

  always_comb begin
    neg_numer = -job.numer;
    mag       = job.numer[32] ? neg_numer[31:0] : job.numer[31:0];
    trial     = {rem, dq[31]};
    diff      = trial - {1'b0, d};
    ge        = trial >= {1'b0, d};
    neg_dq    = -dq;
    if (sat)                    quot = neg ? SAT_MIN : SAT_MAX;
    else if (!neg)              quot = dq[31] ? SAT_MAX : dq;
    else if (dq > 32'h8000_0000) quot = SAT_MIN;
    else                        quot = neg_dq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (!job.need_div) begin
              result <= '{job.pass_value, job.cur_min, job.cur_max};
            end else begin
              d        <= job.divisor;
              neg      <= job.numer[32];
              // quotient of 2^32 or more saturates; skip those bits
              sat      <= {16'b0, mag[31:16]} >= job.divisor;
              rem      <= {16'b0, mag[31:16]};
              dq       <= {mag[15:0], 16'b0};
              cnt      <= '0;
              hold_min <= job.cur_min;
              hold_max <= job.cur_max;
              state    <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          rem <= ge ? diff[31:0] : trial[31:0];
          dq  <= {dq[30:0], ge};
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            result <= '{quot, hold_min, hold_max};
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/min_max_tracker_normalizer.sv
// Top level of the min/max tracker normalizer: config port, front, queue, back.
//
// Sample channel (sample_valid/sample_stall/sample) carries op, tracker_index
// and sample_value; result channel (result_valid/result_stall/result) returns
// normalized_value, current_min and current_max, one result per item, in order.
// The front takes one item per cycle while the two-entry job queue has room;
// update, clear and pass-through items go through a queue entry to the result
// register once the back is idle and the output is free. A normalize with a
// positive span runs the back's radix-2 divider: a setup step, the
// shift-subtract steps and a saturation step, and the back takes no new item
// until the divider is through with it. The divider sets the sustained rate.
// delta_floor is written over the APB port at byte addresses 0-3; pready is
// always high. Reset empties all trackers (min 0x7FFFFFFF, max 0x80000000),
// clears delta_floor and drops queued items. While a valid result is stalled
// it holds; the back and then the queue fill, and sample_stall rises.
`include "assert_macros.svh"

module min_max_tracker_normalizer import mmtn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  logic [30:0] delta_floor;
  logic        q_push, q_full, q_pop, q_valid;
  job_t        push_job, pop_job;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DELTA_FLOOR) ? {1'b0, delta_floor} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_floor <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_DELTA_FLOOR)) begin
      delta_floor <= pwdata[30:0];
    end
  end

  assign sample_stall = q_full;

  mmtn_front u_front (
    .clk          (clk),
    .rst          (rst),
    .delta_floor  (delta_floor),
    .sample_valid (sample_valid),
    .sample       (sample),
    .q_full       (q_full),
    .push         (q_push),
    .job          (push_job)
  );

  mmtn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .pop_job  (pop_job)
  );

  mmtn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .job          (pop_job),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

  `ASSERT_CLK_NR(a_reset_no_result, rst |=> !result_valid, "result valid after reset")
  `ASSERT_CLK(a_pop_needs_item, q_pop |-> q_valid, "back popped an empty queue")
  `ASSERT_CLK(a_push_has_room, q_push |-> !q_full, "front pushed into a full queue")

endmodule
